[rtl/core/rigid_pose_transform_core_defines.svh]
// assertion macros for the rigid pose transform checker
`ifndef RIGID_POSE_TRANSFORM_CORE_DEFINES_SVH
`define RIGID_POSE_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rpt_pkg.sv]
// shared types and constants of the rigid pose transform core
`default_nettype none

package rpt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned FracQ   = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned TdataW  = 160;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [QuatW-1:0]  quat_t;

  localparam quat_t QuatOne = quat_t'(16384);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRANS_X = 3'd0,
    REG_TRANS_Y = 3'd1,
    REG_TRANS_Z = 3'd2,
    REG_ROT_X   = 3'd3,
    REG_ROT_Y   = 3'd4,
    REG_ROT_Z   = 3'd5,
    REG_ROT_W   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    coord_t tr_x;
    coord_t tr_y;
    coord_t tr_z;
    quat_t  q_x;
    quat_t  q_y;
    quat_t  q_z;
    quat_t  q_w;
  } cfg_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    quat_t  ox;
    quat_t  oy;
    quat_t  oz;
    quat_t  ow;
  } pose_t;

endpackage

`default_nettype wire

[rtl/core/rpt_pipe.sv]
// five-stage pipelined datapath: vector rotation, translation and quaternion product
`default_nettype none

module rpt_pipe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpt_pkg::cfg_t  cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpt_pkg::pose_t in_pose_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpt_pkg::pose_t out_pose_o,
  output logic          out_ovf_o
);
  import rpt_pkg::*;

  localparam int unsigned NStg = 5;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] rdy;

  always_comb begin
    rdy[NStg-1] = !vld_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NStg-1];

  // stage 1: q x v cross terms and the sixteen quaternion products
  logic signed [47:0] s1_qv_q [6];
  logic signed [31:0] s1_op_q [16];
  coord_t             s1_v_q  [3];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_qv_q[0] <= cfg_i.q_y * in_pose_i.pz;
      s1_qv_q[1] <= cfg_i.q_z * in_pose_i.py;
      s1_qv_q[2] <= cfg_i.q_z * in_pose_i.px;
      s1_qv_q[3] <= cfg_i.q_x * in_pose_i.pz;
      s1_qv_q[4] <= cfg_i.q_x * in_pose_i.py;
      s1_qv_q[5] <= cfg_i.q_y * in_pose_i.px;
      s1_op_q[0]  <= cfg_i.q_w * in_pose_i.ox;
      s1_op_q[1]  <= cfg_i.q_x * in_pose_i.ow;
      s1_op_q[2]  <= cfg_i.q_y * in_pose_i.oz;
      s1_op_q[3]  <= cfg_i.q_z * in_pose_i.oy;
      s1_op_q[4]  <= cfg_i.q_w * in_pose_i.oy;
      s1_op_q[5]  <= cfg_i.q_x * in_pose_i.oz;
      s1_op_q[6]  <= cfg_i.q_y * in_pose_i.ow;
      s1_op_q[7]  <= cfg_i.q_z * in_pose_i.ox;
      s1_op_q[8]  <= cfg_i.q_w * in_pose_i.oz;
      s1_op_q[9]  <= cfg_i.q_x * in_pose_i.oy;
      s1_op_q[10] <= cfg_i.q_y * in_pose_i.ox;
      s1_op_q[11] <= cfg_i.q_z * in_pose_i.ow;
      s1_op_q[12] <= cfg_i.q_w * in_pose_i.ow;
      s1_op_q[13] <= cfg_i.q_x * in_pose_i.ox;
      s1_op_q[14] <= cfg_i.q_y * in_pose_i.oy;
      s1_op_q[15] <= cfg_i.q_z * in_pose_i.oz;
      s1_v_q[0] <= in_pose_i.px;
      s1_v_q[1] <= in_pose_i.py;
      s1_v_q[2] <= in_pose_i.pz;
    end
  end

  // stage 2: t = round(2 * (q x v)), and the rounded, saturated quaternion
  logic signed [49:0] s2_ts  [3];
  logic signed [35:0] s2_t_d [3];
  logic signed [33:0] s2_os  [4];
  quat_t              s2_o_d [4];
  logic [3:0]         s2_of;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_ts[i] = ((50'(s1_qv_q[2*i]) - 50'(s1_qv_q[2*i+1])) <<< 1) + 50'sd8192;
      s2_t_d[i] = s2_ts[i][49:FracQ];
    end
    s2_os[0] = 34'(s1_op_q[0]) + 34'(s1_op_q[1]) + 34'(s1_op_q[2]) - 34'(s1_op_q[3]);
    s2_os[1] = 34'(s1_op_q[4]) - 34'(s1_op_q[5]) + 34'(s1_op_q[6]) + 34'(s1_op_q[7]);
    s2_os[2] = 34'(s1_op_q[8]) + 34'(s1_op_q[9]) - 34'(s1_op_q[10]) + 34'(s1_op_q[11]);
    s2_os[3] = 34'(s1_op_q[12]) - 34'(s1_op_q[13]) - 34'(s1_op_q[14]) - 34'(s1_op_q[15]);
    for (int i = 0; i < 4; i++) begin
      s2_os[i] = s2_os[i] + 34'sd8192;
      // rounded value lives in bits 33:14, fits when bits 33:29 agree
      s2_of[i] = !((&s2_os[i][33:29]) || !(|s2_os[i][33:29]));
      if (!s2_of[i]) begin
        s2_o_d[i] = s2_os[i][29:FracQ];
      end else if (s2_os[i][33]) begin
        s2_o_d[i] = quat_t'(16'sh8000);
      end else begin
        s2_o_d[i] = quat_t'(16'sh7fff);
      end
    end
  end

  logic signed [35:0] s2_t_q [3];
  coord_t             s2_v_q [3];
  quat_t              s2_o_q [4];
  logic               s2_ovf_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_t_q   <= s2_t_d;
      s2_v_q   <= s1_v_q;
      s2_o_q   <= s2_o_d;
      s2_ovf_q <= |s2_of;
    end
  end

  // stage 3: w*t and the q x t cross terms
  logic signed [51:0] s3_pr_q [9];
  coord_t             s3_v_q  [3];
  quat_t              s3_o_q  [4];
  logic               s3_ovf_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_pr_q[0] <= cfg_i.q_w * s2_t_q[0];
      s3_pr_q[1] <= cfg_i.q_y * s2_t_q[2];
      s3_pr_q[2] <= cfg_i.q_z * s2_t_q[1];
      s3_pr_q[3] <= cfg_i.q_w * s2_t_q[1];
      s3_pr_q[4] <= cfg_i.q_z * s2_t_q[0];
      s3_pr_q[5] <= cfg_i.q_x * s2_t_q[2];
      s3_pr_q[6] <= cfg_i.q_w * s2_t_q[2];
      s3_pr_q[7] <= cfg_i.q_x * s2_t_q[1];
      s3_pr_q[8] <= cfg_i.q_y * s2_t_q[0];
      s3_v_q   <= s2_v_q;
      s3_o_q   <= s2_o_q;
      s3_ovf_q <= s2_ovf_q;
    end
  end

  // stage 4: r = round(w*t + q x t), and v + trans in parallel
  logic signed [52:0] s4_rs  [3];
  logic signed [38:0] s4_r_d [3];
  logic signed [32:0] s4_vt_d [3];
  coord_t             s4_tr  [3];

  always_comb begin
    s4_tr[0] = cfg_i.tr_x;
    s4_tr[1] = cfg_i.tr_y;
    s4_tr[2] = cfg_i.tr_z;
    for (int i = 0; i < 3; i++) begin
      s4_rs[i] = 53'(s3_pr_q[3*i]) + 53'(s3_pr_q[3*i+1]) - 53'(s3_pr_q[3*i+2])
               + 53'sd8192;
      s4_r_d[i]  = s4_rs[i][52:FracQ];
      s4_vt_d[i] = 33'(s3_v_q[i]) + 33'(s4_tr[i]);
    end
  end

  logic signed [38:0] s4_r_q  [3];
  logic signed [32:0] s4_vt_q [3];
  quat_t              s4_o_q  [4];
  logic               s4_ovf_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_r_q   <= s4_r_d;
      s4_vt_q  <= s4_vt_d;
      s4_o_q   <= s3_o_q;
      s4_ovf_q <= s3_ovf_q;
    end
  end

  // stage 5: final sum and saturation into the output register
  logic signed [39:0] s5_ps  [3];
  coord_t             s5_p_d [3];
  logic [2:0]         s5_of;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_ps[i] = 40'(s4_vt_q[i]) + 40'(s4_r_q[i]);
      s5_of[i] = !((&s5_ps[i][39:31]) || !(|s5_ps[i][39:31]));
      if (!s5_of[i]) begin
        s5_p_d[i] = s5_ps[i][31:0];
      end else if (s5_ps[i][39]) begin
        s5_p_d[i] = coord_t'(32'sh8000_0000);
      end else begin
        s5_p_d[i] = coord_t'(32'sh7fff_ffff);
      end
    end
  end

  pose_t out_q;
  logic  ovf_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      out_q.px <= s5_p_d[0];
      out_q.py <= s5_p_d[1];
      out_q.pz <= s5_p_d[2];
      out_q.ox <= s4_o_q[0];
      out_q.oy <= s4_o_q[1];
      out_q.oz <= s4_o_q[2];
      out_q.ow <= s4_o_q[3];
      ovf_q    <= s4_ovf_q || (|s5_of);
    end
  end

  assign out_pose_o = out_q;
  assign out_ovf_o  = ovf_q;

endmodule

`default_nettype wire

[rtl/core/rigid_pose_transform_core.sv]
// top level: configuration registers and stream ports around the transform pipeline
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: pose (160 bits)
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pose (160), tuser: overflow
//  cfg       in         cfg_we_i                     cfg_idx_i, cfg_data_i
//
//  one pose per cycle sustained while the output is not stalled; the five register
//  stages are two multiplier stages, two adder/rounding stages and the saturating
//  output register, and m_axis_tvalid is the valid bit of that output register
//  every stage has its own valid bit and loads whenever its successor can move on,
//  so bubbles close up and a stalled output only holds the stages behind it
//  reset empties the pipeline and loads the identity transform
`default_nettype none

module rigid_pose_transform_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpt_pkg::CfgDatW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z, ori_x, ori_y, ori_z, ori_w
  input  logic [rpt_pkg::TdataW-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_ori_x, out_ori_y, out_ori_z, out_ori_w
  output logic [rpt_pkg::TdataW-1:0]    m_axis_tdata,
  // overflow
  output logic                          m_axis_tuser
);
  import rpt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tr_x <= '0;
      cfg_q.tr_y <= '0;
      cfg_q.tr_z <= '0;
      cfg_q.q_x  <= '0;
      cfg_q.q_y  <= '0;
      cfg_q.q_z  <= '0;
      cfg_q.q_w  <= QuatOne;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TRANS_X: cfg_q.tr_x <= cfg_data_i;
        REG_TRANS_Y: cfg_q.tr_y <= cfg_data_i;
        REG_TRANS_Z: cfg_q.tr_z <= cfg_data_i;
        REG_ROT_X:   cfg_q.q_x  <= cfg_data_i[QuatW-1:0];
        REG_ROT_Y:   cfg_q.q_y  <= cfg_data_i[QuatW-1:0];
        REG_ROT_Z:   cfg_q.q_z  <= cfg_data_i[QuatW-1:0];
        REG_ROT_W:   cfg_q.q_w  <= cfg_data_i[QuatW-1:0];
        default: ;
      endcase
    end
  end

  pose_t in_pose;
  pose_t out_pose;

  assign in_pose.px = s_axis_tdata[31:0];
  assign in_pose.py = s_axis_tdata[63:32];
  assign in_pose.pz = s_axis_tdata[95:64];
  assign in_pose.ox = s_axis_tdata[111:96];
  assign in_pose.oy = s_axis_tdata[127:112];
  assign in_pose.oz = s_axis_tdata[143:128];
  assign in_pose.ow = s_axis_tdata[159:144];

  rpt_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pose_i   (in_pose),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pose_o  (out_pose),
    .out_ovf_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {out_pose.ow, out_pose.oz, out_pose.oy, out_pose.ox,
                         out_pose.pz, out_pose.py, out_pose.px};

endmodule

`default_nettype wire

[rtl/core/rpt_checker.sv]
// port-level checks of the rigid pose transform core, bound to the top level
`default_nettype none
`include "rigid_pose_transform_core_defines.svh"

module rpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rpt_pkg::TdataW-1:0]  m_axis_tdata,
  input logic                        m_axis_tuser
);
  import rpt_pkg::*;

  logic out_stall;
  logic at_bound;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // with overflow flagged at least one field sits on a saturation limit
  assign at_bound =
      (m_axis_tdata[31:0]    == 32'h7fff_ffff) || (m_axis_tdata[31:0]    == 32'h8000_0000) ||
      (m_axis_tdata[63:32]   == 32'h7fff_ffff) || (m_axis_tdata[63:32]   == 32'h8000_0000) ||
      (m_axis_tdata[95:64]   == 32'h7fff_ffff) || (m_axis_tdata[95:64]   == 32'h8000_0000) ||
      (m_axis_tdata[111:96]  == 16'h7fff)      || (m_axis_tdata[111:96]  == 16'h8000)      ||
      (m_axis_tdata[127:112] == 16'h7fff)      || (m_axis_tdata[127:112] == 16'h8000)      ||
      (m_axis_tdata[143:128] == 16'h7fff)      || (m_axis_tdata[143:128] == 16'h8000)      ||
      (m_axis_tdata[159:144] == 16'h7fff)      || (m_axis_tdata[159:144] == 16'h8000);

  // input side only backs up when the whole pipeline is full behind a stalled output
  `RPT_ASSERT_IMPLY(a_ready_only_on_stall, clk_i, rst_ni, !s_axis_tready, out_stall, "input blocked without output stall")

  `RPT_ASSERT_IMPLY(a_ovf_at_limit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, at_bound, "overflow flagged but no field saturated")

  `RPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind rigid_pose_transform_core rpt_checker u_rpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/testbench.sv]
// self-checking stream testbench for rigid_pose_transform_core
`default_nettype none

module testbench;
  import rpt_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 10;

  localparam coord_t CoordMax = 32'sh7fffffff;
  localparam coord_t CoordMin = 32'sh80000000;
  localparam quat_t  QuatMax  = 16'sh7fff;
  localparam quat_t  QuatMin  = 16'sh8000;

  typedef struct {
    coord_t pos[3];
    quat_t  ori[4];
    logic   ovf;
  } pose_result_t;

  class pose_tf_board;
    pose_result_t expected_poses[$];
    longint tr[3];
    longint rq[3];
    longint rw;
    bit     sat_hit;
    int     fail_cnt;
    string  pos_names[3] = '{"out_pos_x", "out_pos_y", "out_pos_z"};
    string  ori_names[4] = '{"out_ori_x", "out_ori_y", "out_ori_z", "out_ori_w"};

    function new();
      for (int i = 0; i < 3; i++) begin
        tr[i] = 0;
        rq[i] = 0;
      end
      rw = QuatOne;
      fail_cnt = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        REG_TRANS_X: tr[0] = $signed(data);
        REG_TRANS_Y: tr[1] = $signed(data);
        REG_TRANS_Z: tr[2] = $signed(data);
        REG_ROT_X:   rq[0] = $signed(data[QuatW-1:0]);
        REG_ROT_Y:   rq[1] = $signed(data[QuatW-1:0]);
        REG_ROT_Z:   rq[2] = $signed(data[QuatW-1:0]);
        REG_ROT_W:   rw = $signed(data[QuatW-1:0]);
        default: ;
      endcase
    endfunction

    // round half up, arithmetic shift gives the floor
    function longint rnd(longint x);
      return (x + (longint'(1) << (FracQ - 1))) >>> FracQ;
    endfunction

    function longint clamp(longint x, int unsigned w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
        sat_hit = 1'b1;
        return hi;
      end
      if (x < lo) begin
        sat_hit = 1'b1;
        return lo;
      end
      return x;
    endfunction

    function void note_pose(logic [TdataW-1:0] d);
      pose_result_t e;
      longint v[3];
      longint o[4];
      longint tq[3];
      longint rr[3];
      sat_hit = 1'b0;
      for (int i = 0; i < 3; i++) v[i] = $signed(d[32*i +: 32]);
      for (int k = 0; k < 4; k++) o[k] = $signed(d[96+16*k +: 16]);
      // t = 2 (q x v), then v' = v + w t + q x t
      tq[0] = rnd(2 * (rq[1] * v[2] - rq[2] * v[1]));
      tq[1] = rnd(2 * (rq[2] * v[0] - rq[0] * v[2]));
      tq[2] = rnd(2 * (rq[0] * v[1] - rq[1] * v[0]));
      rr[0] = rnd(rw * tq[0] + (rq[1] * tq[2] - rq[2] * tq[1]));
      rr[1] = rnd(rw * tq[1] + (rq[2] * tq[0] - rq[0] * tq[2]));
      rr[2] = rnd(rw * tq[2] + (rq[0] * tq[1] - rq[1] * tq[0]));
      for (int i = 0; i < 3; i++) e.pos[i] = coord_t'(clamp(v[i] + rr[i] + tr[i], CoordW));
      // hamilton product, configured rotation on the left
      e.ori[0] = quat_t'(clamp(rnd(rw*o[0] + rq[0]*o[3] + rq[1]*o[2] - rq[2]*o[1]), QuatW));
      e.ori[1] = quat_t'(clamp(rnd(rw*o[1] - rq[0]*o[2] + rq[1]*o[3] + rq[2]*o[0]), QuatW));
      e.ori[2] = quat_t'(clamp(rnd(rw*o[2] + rq[0]*o[1] - rq[1]*o[0] + rq[2]*o[3]), QuatW));
      e.ori[3] = quat_t'(clamp(rnd(rw*o[3] - rq[0]*o[0] - rq[1]*o[1] - rq[2]*o[2]), QuatW));
      e.ovf = sat_hit;
      expected_poses.insert(expected_poses.size(), e);
    endfunction

    function void check_result(logic [TdataW-1:0] d, logic ovf);
      pose_result_t e;
      if (expected_poses.size() == 0) begin
        $error("result transfer with no pose waiting");
        fail_cnt++;
        return;
      end
      e = expected_poses.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (d[32*i +: 32] !== e.pos[i]) begin
          $error("%s expected %0d actual %0d", pos_names[i], e.pos[i],
                 $signed(d[32*i +: 32]));
          fail_cnt++;
        end
      end
      for (int k = 0; k < 4; k++) begin
        if (d[96+16*k +: 16] !== e.ori[k]) begin
          $error("%s expected %0d actual %0d", ori_names[k], e.ori[k],
                 $signed(d[96+16*k +: 16]));
          fail_cnt++;
        end
      end
      if (ovf !== e.ovf) begin
        $error("overflow expected %0d actual %0d", e.ovf, ovf);
        fail_cnt++;
      end
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata;
  logic                m_axis_tuser;

  pose_tf_board board = new();
  bit          tx_idle_ok = 1'b1;
  bit          rx_idle_ok = 1'b1;
  int unsigned cycle_cnt = 0;

  rigid_pose_transform_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // input and output transfers as seen at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_pose(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [TdataW-1:0] pack_pose(coord_t x, coord_t y, coord_t z,
                                                  quat_t a, quat_t b, quat_t c, quat_t d);
    return {d, c, b, a, z, y, x};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2, 3, 4: return coord_t'($urandom());
      default: return coord_t'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic quat_t rand_quat();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return QuatMax;
          1: return QuatMin;
          2: return '0;
          default: return QuatOne;
        endcase
      end
      1, 2, 3: return quat_t'($urandom());
      default: return quat_t'(int'($urandom_range(0, 24576)) - 12288);
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  // rotation registers get junk in the unused high bits
  task automatic load_transform(coord_t tx, coord_t ty, coord_t tz,
                                quat_t rx, quat_t ry, quat_t rz, quat_t rw);
    write_reg(REG_TRANS_X, tx);
    write_reg(REG_TRANS_Y, ty);
    write_reg(REG_TRANS_Z, tz);
    write_reg(REG_ROT_X, {16'($urandom()), rx});
    write_reg(REG_ROT_Y, {16'($urandom()), ry});
    write_reg(REG_ROT_Z, {16'($urandom()), rz});
    write_reg(REG_ROT_W, {16'($urandom()), rw});
  endtask

  task automatic random_transform();
    case ($urandom_range(0, 3))
      0: load_transform(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                        quat_t'($urandom()), quat_t'($urandom()), quat_t'($urandom()),
                        quat_t'($urandom()));
      1: load_transform(rand_coord(), rand_coord(), rand_coord(),
                        quat_t'(int'($urandom_range(0, 8192)) - 4096),
                        quat_t'(int'($urandom_range(0, 8192)) - 4096),
                        quat_t'(int'($urandom_range(0, 8192)) - 4096),
                        quat_t'(int'($urandom_range(12000, 16384))));
      2: load_transform($urandom_range(0, 1) ? CoordMax : CoordMin,
                        $urandom_range(0, 1) ? CoordMax : CoordMin,
                        $urandom_range(0, 1) ? CoordMax : CoordMin,
                        $urandom_range(0, 1) ? QuatMax : QuatMin,
                        $urandom_range(0, 1) ? QuatMax : QuatMin,
                        $urandom_range(0, 1) ? QuatMax : QuatMin,
                        $urandom_range(0, 1) ? QuatMax : QuatMin);
      default: load_transform(rand_coord(), rand_coord(), rand_coord(),
                              rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(RegUnused, $urandom());
  endtask

  task automatic send_pose(logic [TdataW-1:0] d);
    if (tx_idle_ok && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_pose();
    send_pose(pack_pose(rand_coord(), rand_coord(), rand_coord(),
                        rand_quat(), rand_quat(), rand_quat(), rand_quat()));
  endtask

  // hold the sender until every expected result has been checked
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_extremes();
    send_pose(pack_pose(0, 0, 0, '0, '0, '0, '0));
    send_pose(pack_pose(CoordMax, CoordMax, CoordMax, QuatMax, QuatMax, QuatMax, QuatMax));
    send_pose(pack_pose(CoordMin, CoordMin, CoordMin, QuatMin, QuatMin, QuatMin, QuatMin));
    send_pose(pack_pose(CoordMax, CoordMin, CoordMax, QuatMin, QuatMax, QuatMin, QuatMax));
    send_pose(pack_pose(CoordMin, CoordMax, -1, '0, '0, '0, QuatOne));
    send_pose(pack_pose(32'sh00010000, -32'sh00010000, 32'sh00008000,
                        QuatOne, '0, '0, '0));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity transform out of reset
    send_extremes();
    send_random_pose();
    send_random_pose();
    drain();

    // largest translation and rotation, saturates almost everywhere
    load_transform(CoordMax, CoordMax, CoordMax, QuatMax, QuatMax, QuatMax, QuatMax);
    write_reg(RegUnused, 32'hffffffff);
    send_extremes();
    drain();

    load_transform(CoordMin, CoordMin, CoordMin, QuatMin, QuatMin, QuatMin, QuatMin);
    send_extremes();
    drain();

    // quarter turn about z with a small offset
    load_transform(32'sh00020000, -32'sh00030000, 32'sh00000001, '0, '0,
                   16'sd11585, 16'sd11585);
    send_pose(pack_pose(32'sh00010000, 0, 0, '0, '0, '0, QuatOne));
    send_pose(pack_pose(32'sh00008000, 32'sh00004000, -32'sh00010000, '0, '0, '0, QuatOne));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      tx_idle_ok = (ph != 8) && ($urandom_range(0, 4) != 0);
      rx_idle_ok = (ph != 8) && ($urandom_range(0, 4) != 0);
      random_transform();
      for (int n = 0; n < 148; n++) send_random_pose();
      drain();
    end

    if (board.fail_cnt == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/rpt_pkg.sv
rtl/core/rpt_pipe.sv
rtl/core/rigid_pose_transform_core.sv
rtl/core/rpt_checker.sv
sim/testbench.sv
